FILE: hw/rtl/gbns_pkg.sv
`default_nettype none

package gbns_pkg;

  // Input opcodes
  localparam logic [1:0] OP_MSG = 2'd0;
  localparam logic [1:0] OP_ACK = 2'd1;
  localparam logic [1:0] OP_TMO = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_TIMER  = 2'd2;
  localparam logic [1:0] KIND_REFUSE = 2'd3;

  // Timer commands
  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  // Segmentation: 118 payload bytes per segment
  localparam logic [6:0]  SEG_BYTES     = 7'd118;
  localparam logic [6:0]  SEG_ROUND     = 7'd117;
  // ceil(2^24 / 118): floor(x * SEG_RECIP >> 24) == floor(x / 118) for x < 2^17
  localparam logic [17:0] SEG_RECIP     = 18'd142180;
  localparam int          SEG_SHIFT     = 24;
  localparam int          SEGS_W        = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] msg_size;
    logic [31:0] ack_number;
    logic [15:0] ack_tail;
  } gbns_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq_number;
    logic [5:0]  slot;
    logic [6:0]  seg_length;
    logic        seg_last;
    logic [1:0]  timer_cmd;
    logic        last;
  } gbns_res_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       seg_calc;
    logic       enq;
    logic       q_rd;
    logic       send;
    logic       ack_upd;
    logic       rs_init;
    logic       w_rd;
    logic       resend;
    logic       first;
    logic       emit_refuse;
    logic       emit_timer;
    logic [1:0] tcmd;
  } gbns_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       refuse;
    logic       seg_none;
    logic       seg_last;
    logic       can_send;
    logic       ack_ok;
    logic       ack_hits_next;
    logic       ack_moved;
    logic       rs_done;
  } gbns_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/go_back_n_sender_window_top.sv
// Channel   | Direction | Handshake               | Word
// ----------+-----------+-------------------------+------------------------------
// event     | in        | start high, busy low    | in_i   (op, msg_size, ack)
// result    | out       | res_strobe_o, 1 cycle   | res_o  (kind, seq, slot, ...)
//
// Order: a message is decoded, checked (refused if the queue lacks room),
// queued segment by segment and then sent, each send a queue RAM read, then
// a window RAM write; an ACK that empties the window also drains the queue;
// a timeout resends every outstanding segment.
// Reset: asynchronous, active low; sequence numbers restart at 1, queue empty.
// Stalls: the result receiver cannot stall; each result word shows one cycle.
`default_nettype none

module go_back_n_sender_window_top #(
  parameter int WINDOW      = 10,
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Event word: taken when start is high and busy is low
  input  wire logic               start,
  input  wire gbns_pkg::gbns_in_t in_i,
  output logic                    busy,
  // Result word: valid for the single cycle res_strobe_o is high
  output logic                    res_strobe_o,
  output gbns_pkg::gbns_res_t     res_o
);
  import gbns_pkg::*;

  gbns_cmd_t cmd;
  gbns_sts_t sts;

  // Sequence the event: decode, segment, drain the queue, or resend
  gbns_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Hold sequence state, the descriptor queue, the window store and the
  // result register
  gbns_dp #(
    .WINDOW      (WINDOW),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/gbns_ram.sv
`default_nettype none

module gbns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gbns_dp.sv
`default_nettype none

module gbns_dp #(
  parameter int WINDOW      = 10,
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gbns_pkg::gbns_in_t  in_i,
  input  wire gbns_pkg::gbns_cmd_t cmd_i,
  output gbns_pkg::gbns_sts_t      sts_o,
  output gbns_pkg::gbns_res_t      res_o,
  output logic                     res_strobe_o
);
  import gbns_pkg::*;

  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QA_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W      = (CNT_W > SEGS_W) ? CNT_W : SEGS_W;
  localparam int RESET_SLOT = 1 % WINDOW;

  gbns_in_t          in_q;
  logic [SEGS_W-1:0] segs_q;
  logic [15:0]       rem_q;
  logic [31:0]       base_q, base_d, next_q;
  logic [SLOT_W-1:0] base_slot_q, base_slot_d, next_slot_q;
  logic [QA_W-1:0]   head_q, tail_q;
  logic [CNT_W-1:0]  count_q;
  logic [31:0]       rs_seq_q;
  logic [SLOT_W-1:0] rs_slot_q;
  gbns_res_t         res_q, res_d;
  logic              res_valid_q;

  logic [16:0]       seg_x;
  logic [34:0]       seg_prod;
  logic [CNT_W-1:0]  q_free;
  logic [6:0]        seg_len;
  logic [7:0]        enq_desc, q_rdata, w_rdata;
  logic [31:0]       win_used, ack_next, ack_delta;
  logic [7:0]        ack_sum;
  logic [SLOT_W:0]   slot_sum;

  // Segment count by reciprocal multiply, registered below
  assign seg_x    = {1'b0, in_q.msg_size} + 17'(SEG_ROUND);
  assign seg_prod = 35'(seg_x) * 35'(SEG_RECIP);
  assign q_free   = CNT_W'(QUEUE_DEPTH) - count_q;

  assign seg_len  = (rem_q <= 16'(SEG_BYTES)) ? rem_q[6:0] : SEG_BYTES;
  assign enq_desc = {(rem_q <= 16'(SEG_BYTES)), seg_len};

  assign win_used = next_q - base_q;

  // ACK checks
  assign ack_sum   = in_q.ack_number[7:0] + in_q.ack_number[15:8]
                   + in_q.ack_number[23:16] + in_q.ack_number[31:24]
                   + in_q.ack_tail[7:0] + in_q.ack_tail[15:8];
  assign ack_next  = in_q.ack_number + 32'd1;
  assign ack_delta = ack_next - base_q;
  assign slot_sum  = {1'b0, base_slot_q} + ack_delta[SLOT_W:0];

  always_comb begin
    base_d      = base_q;
    base_slot_d = base_slot_q;
    if (cmd_i.ack_upd) begin
      base_d = ack_next;
      // A base that wrapped past zero is below WINDOW and is its own slot
      if (ack_next < ack_delta) begin
        base_slot_d = SLOT_W'(ack_next);
      end else begin
        base_slot_d = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
                      SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : SLOT_W'(slot_sum);
      end
    end
  end

  always_comb begin
    sts_o.op            = in_q.op;
    sts_o.refuse        = CMP_W'(segs_q) > CMP_W'(q_free);
    sts_o.seg_none      = (segs_q == '0);
    sts_o.seg_last      = (rem_q <= 16'(SEG_BYTES));
    sts_o.can_send      = (win_used < 32'(WINDOW)) && (count_q != '0);
    sts_o.ack_ok        = (ack_sum == 8'd0) && (ack_delta <= win_used);
    sts_o.ack_hits_next = (ack_next == next_q);
    sts_o.ack_moved     = (ack_delta != 32'd0);
    sts_o.rs_done       = (rs_seq_q == next_q);
  end

  // Result assembly
  always_comb begin
    res_d = '0;
    if (cmd_i.emit_refuse) begin
      res_d.kind = KIND_REFUSE;
      res_d.last = 1'b1;
    end else if (cmd_i.emit_timer) begin
      res_d.kind      = KIND_TIMER;
      res_d.timer_cmd = cmd_i.tcmd;
      res_d.last      = 1'b1;
    end else if (cmd_i.send) begin
      res_d.kind       = KIND_SEND;
      res_d.seq_number = next_q;
      res_d.slot       = 6'(next_slot_q);
      res_d.seg_length = q_rdata[6:0];
      res_d.seg_last   = q_rdata[7];
      res_d.timer_cmd  = (base_q == next_q) ? TMR_START : TMR_NONE;
      res_d.last       = !((win_used < 32'(WINDOW - 1)) && (count_q > CNT_W'(1)));
    end else if (cmd_i.resend) begin
      res_d.kind       = KIND_RESEND;
      res_d.seq_number = rs_seq_q;
      res_d.slot       = 6'(rs_slot_q);
      res_d.seg_length = w_rdata[6:0];
      res_d.seg_last   = w_rdata[7];
      res_d.timer_cmd  = cmd_i.first ? TMR_START : TMR_NONE;
      res_d.last       = (rs_seq_q + 32'd1 == next_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 32'd1;
      next_q      <= 32'd1;
      base_slot_q <= SLOT_W'(RESET_SLOT);
      next_slot_q <= SLOT_W'(RESET_SLOT);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      base_slot_q <= base_slot_d;
      res_valid_q <= cmd_i.emit_refuse | cmd_i.emit_timer | cmd_i.send | cmd_i.resend;
      if (cmd_i.enq) begin
        tail_q  <= (tail_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QA_W'(1);
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.send) begin
        head_q      <= (head_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QA_W'(1);
        count_q     <= count_q - CNT_W'(1);
        next_q      <= next_q + 32'd1;
        next_slot_q <= ((next_q == 32'hFFFF_FFFF) ||
                        (next_slot_q == SLOT_W'(WINDOW - 1))) ? '0
                                                              : next_slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.seg_calc) begin
      segs_q <= seg_prod[SEG_SHIFT +: SEGS_W];
      rem_q  <= in_q.msg_size;
    end else if (cmd_i.enq) begin
      rem_q  <= rem_q - 16'(SEG_BYTES);
    end
    if (cmd_i.rs_init) begin
      rs_seq_q  <= base_q;
      rs_slot_q <= base_slot_q;
    end else if (cmd_i.resend) begin
      rs_seq_q  <= rs_seq_q + 32'd1;
      rs_slot_q <= ((rs_seq_q == 32'hFFFF_FFFF) ||
                    (rs_slot_q == SLOT_W'(WINDOW - 1))) ? '0 : rs_slot_q + SLOT_W'(1);
    end
  end

  gbns_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH),
    .AW    (QA_W)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq),
    .waddr_i (tail_q),
    .wdata_i (enq_desc),
    .re_i    (cmd_i.q_rd),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  gbns_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.send),
    .waddr_i (next_slot_q),
    .wdata_i (q_rdata),
    .re_i    (cmd_i.w_rd),
    .raddr_i (rs_slot_q),
    .rdata_o (w_rdata)
  );

  assign res_o        = res_q;
  assign res_strobe_o = res_valid_q;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q - base_q) <= 32'(WINDOW))
    else $error("more segments outstanding than the window");

  a_send_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.send |-> $past(cmd_i.q_rd))
    else $error("send without a queue read the cycle before");

  a_enq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq |-> count_q < CNT_W'(QUEUE_DEPTH))
    else $error("enqueue into a full queue");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/gbns_ctrl.sv
`default_nettype none

module gbns_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire gbns_pkg::gbns_sts_t sts_i,
  output gbns_pkg::gbns_cmd_t      cmd_o,
  output logic                     busy_o
);
  import gbns_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_ENQ  = 9'b000001000,
    S_SRD  = 9'b000010000,
    S_SWR  = 9'b000100000,
    S_ACK  = 9'b001000000,
    S_RRD  = 9'b010000000,
    S_RWR  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   sent_any_q, sent_any_d;
  logic   stop_pend_q, stop_pend_d;
  logic   first_q, first_d;

  always_comb begin
    state_d     = state_q;
    sent_any_d  = sent_any_q;
    stop_pend_d = stop_pend_q;
    first_d     = first_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.op)
          OP_MSG: begin
            cmd_o.seg_calc = 1'b1;
            state_d        = S_CHK;
          end
          OP_ACK: begin
            state_d = S_ACK;
          end
          OP_TMO: begin
            cmd_o.rs_init = 1'b1;
            first_d       = 1'b1;
            state_d       = S_RRD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_CHK: begin
        sent_any_d  = 1'b0;
        stop_pend_d = 1'b0;
        if (sts_i.refuse) begin
          cmd_o.emit_refuse = 1'b1;
          state_d           = S_IDLE;
        end else if (sts_i.seg_none) begin
          state_d = S_SRD;
        end else begin
          state_d = S_ENQ;
        end
      end
      S_ENQ: begin
        cmd_o.enq = 1'b1;
        if (sts_i.seg_last) begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (sts_i.can_send) begin
          cmd_o.q_rd = 1'b1;
          state_d    = S_SWR;
        end else begin
          if (stop_pend_q && !sent_any_q) begin
            cmd_o.emit_timer = 1'b1;
            cmd_o.tcmd       = TMR_STOP;
          end
          state_d = S_IDLE;
        end
      end
      S_SWR: begin
        cmd_o.send = 1'b1;
        sent_any_d = 1'b1;
        state_d    = S_SRD;
      end
      S_ACK: begin
        state_d = S_IDLE;
        if (sts_i.ack_ok) begin
          cmd_o.ack_upd = 1'b1;
          if (sts_i.ack_hits_next) begin
            stop_pend_d = 1'b1;
            sent_any_d  = 1'b0;
            state_d     = S_SRD;
          end else if (sts_i.ack_moved) begin
            cmd_o.emit_timer = 1'b1;
            cmd_o.tcmd       = TMR_START;
          end
        end
      end
      S_RRD: begin
        if (sts_i.rs_done) begin
          if (first_q) begin
            cmd_o.emit_timer = 1'b1;
            cmd_o.tcmd       = TMR_START;
          end
          state_d = S_IDLE;
        end else begin
          cmd_o.w_rd = 1'b1;
          state_d    = S_RWR;
        end
      end
      S_RWR: begin
        cmd_o.resend = 1'b1;
        cmd_o.first  = first_q;
        first_d      = 1'b0;
        state_d      = S_RRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sent_any_q  <= 1'b0;
      stop_pend_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      sent_any_q  <= sent_any_d;
      stop_pend_q <= stop_pend_d;
      first_q     <= first_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_resend_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RWR) && first_q |=> (state_q == S_RRD) && !first_q)
    else $error("first resend flag not cleared");
`endif

endmodule

`default_nettype wire
